FILE: sv/mx3_pkg.sv
// ----------------------------------------------------------------------------
// mx3_pkg
// Shared widths, datapath control types and index helpers for the 3x3 matrix
// arithmetic unit.
// ----------------------------------------------------------------------------
package mx3_pkg;

  // element and result field widths
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned PROD_W   = 33;
  localparam int unsigned DET_W    = 49;

  // store geometry
  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned ADDR_W   = 4;

  // accumulator widths: product sums and cofactors fit in ACC_W,
  // the determinant sum of three terms fits in DACC_W
  localparam int unsigned ACC_W    = 35;
  localparam int unsigned DACC_W   = 50;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ELEM - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(2);

  // what the accumulate stage does with a finished product
  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB,
    DA_ADD,
    DA_SUB,
    DB_ADD,
    DB_SUB
  } mac_op_e;

  typedef enum logic {
    X_A0,
    X_B0
  } x_sel_e;

  typedef enum logic [1:0] {
    Y_A1,
    Y_B1,
    Y_ACC
  } y_sel_e;

  typedef struct packed {
    mac_op_e op;
    x_sel_e  x_sel;
    y_sel_e  y_sel;
  } mac_ctl_t;

  // row-major address of element (r, c)
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [ADDR_W-1:0] rx;
    rx = ADDR_W'(r);
    return (rx << 1) + rx + ADDR_W'(c);
  endfunction

  // 2x2 minor operands: minor = m[s0]*m[s1] - m[s2]*m[s3]
  function automatic logic [ADDR_W-1:0] cof_addr(input logic [1:0] cof,
                                                 input logic [1:0] slot);
    logic [ADDR_W-1:0] res;
    case ({cof, slot})
      4'b00_00: res = 4'd4;
      4'b00_01: res = 4'd8;
      4'b00_10: res = 4'd7;
      4'b00_11: res = 4'd5;
      4'b01_00: res = 4'd3;
      4'b01_01: res = 4'd8;
      4'b01_10: res = 4'd6;
      4'b01_11: res = 4'd5;
      4'b10_00: res = 4'd3;
      4'b10_01: res = 4'd7;
      4'b10_10: res = 4'd6;
      4'b10_11: res = 4'd4;
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: sv/mx3_stream_if.sv
// ----------------------------------------------------------------------------
// mx3 stream interfaces
// Valid/ready channels for matrix element loads and for result elements.
// ----------------------------------------------------------------------------
interface mx3_in_if;
  import mx3_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a_value;
  logic signed [ELEM_W-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink (input valid, input a_value, input b_value, output ready);
endinterface

interface mx3_out_if;
  import mx3_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  difference;
  logic signed [PROD_W-1:0] product;
  logic signed [ELEM_W-1:0] transpose_a;
  logic signed [ELEM_W-1:0] transpose_b;
  logic signed [DET_W-1:0]  det_a;
  logic signed [DET_W-1:0]  det_b;
  logic                     last;

  modport source (output valid, output row, output col, output sum, output difference,
                  output product, output transpose_a, output transpose_b,
                  output det_a, output det_b, output last, input ready);
  modport sink (input valid, input row, input col, input sum, input difference,
                input product, input transpose_a, input transpose_b,
                input det_a, input det_b, input last, output ready);
endinterface

FILE: sv/matrix3x3_arith_unit_core.sv
// ----------------------------------------------------------------------------
// matrix3x3_arith_unit_core
// Loads two 3x3 signed matrices one element pair per transfer, then streams
// nine result elements (sum, difference, product, transposes, determinants).
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                        | transfer
//  --------+-----+-----------------------------------------------+------------------
//  in_i    | in  | a_value, b_value                              | valid && ready
//  out_o   | out | row, col, sum, difference, product,           | valid && ready
//          |     | transpose_a, transpose_b, det_a, det_b, last  |
//
//  sequence: a set is loaded, then both determinants are computed, then each
//    result element is computed and emitted in turn; no new set is taken until
//    the last result element has entered the output register; the single shared
//    multiplier and its read-multiply-accumulate pipeline set the pace
//  reset: rst_ni clears the sequencer, load count and output valid; the
//    element stores are not cleared
//  stalls: in_i.ready is high only while loading; a stalled result holds the
//    sequencer in its emit step, the loaded set and pipeline stay put
//
module matrix3x3_arith_unit_core (
  input logic       clk_i,
  input logic       rst_ni,
  mx3_in_if.sink    in_i,
  mx3_out_if.source out_o
);
  import mx3_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DET,
    ST_PROD,
    ST_EMIT
  } state_e;

  // determinant sub-steps per cofactor: two minor products, one bubble while
  // the minor settles in the accumulator, then the weighted cofactor product
  localparam logic [2:0] DET_T0  = 3'd0;
  localparam logic [2:0] DET_T1  = 3'd1;
  localparam logic [2:0] DET_MUL = 3'd3;
  // product element sub-steps: three multiply-accumulates, then the pipeline drains
  localparam logic [2:0] PROD_LAST_MAC = 3'd2;
  localparam logic [2:0] PROD_DONE     = 3'd4;
  localparam logic [1:0] LAST_COF      = 2'd2;
  localparam logic [1:0] NEG_COF       = 2'd1;

  // sequencer state
  state_e           state_q;
  logic [ADDR_W-1:0] load_cnt_q;
  logic             mat_q;       // 0: matrix a, 1: matrix b
  logic [1:0]       cof_q;
  logic [2:0]       step_q;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;

  // element stores, two registered read ports each
  logic signed [ELEM_W-1:0] store_a [NUM_ELEM];
  logic signed [ELEM_W-1:0] store_b [NUM_ELEM];
  logic [ADDR_W-1:0]        rd_addr0;
  logic [ADDR_W-1:0]        rd_addr1;
  logic signed [ELEM_W-1:0] rd_a0_q;
  logic signed [ELEM_W-1:0] rd_a1_q;
  logic signed [ELEM_W-1:0] rd_b0_q;
  logic signed [ELEM_W-1:0] rd_b1_q;

  // shared multiply-accumulate pipeline
  mac_ctl_t                        ctl;
  mac_ctl_t                        ctl1_q;
  mac_op_e                         op2_q;
  logic signed [ELEM_W-1:0]        mul_x;
  logic signed [ACC_W-1:0]         mul_y;
  logic signed [ELEM_W+ACC_W-1:0]  mul_full;
  logic signed [DACC_W-1:0]        prod_q;
  logic signed [ACC_W-1:0]         acc_q;
  logic signed [DACC_W-1:0]        det_a_q;
  logic signed [DACC_W-1:0]        det_b_q;

  // output register
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q;
  logic [IDX_W-1:0]         out_col_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic signed [SUM_W-1:0]  out_diff_q;
  logic signed [PROD_W-1:0] out_prod_q;
  logic signed [ELEM_W-1:0] out_tr_a_q;
  logic signed [ELEM_W-1:0] out_tr_b_q;
  logic signed [DET_W-1:0]  out_det_a_q;
  logic signed [DET_W-1:0]  out_det_b_q;
  logic                     out_last_q;

  logic in_fire;
  logic set_done;
  logic out_free;
  logic last_elem;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign set_done   = in_fire && (load_cnt_q == LAST_ADDR);
  // output register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_elem  = (row_q == LAST_IDX) && (col_q == LAST_IDX);

  // --------------------------------------------------------------------------
  // element stores: one write port for loading, two read ports per matrix
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_a[load_cnt_q] <= in_i.a_value;
      store_b[load_cnt_q] <= in_i.b_value;
    end
    rd_a0_q <= store_a[rd_addr0];
    rd_a1_q <= store_a[rd_addr1];
    rd_b0_q <= store_b[rd_addr0];
    rd_b1_q <= store_b[rd_addr1];
  end

  // --------------------------------------------------------------------------
  // step decode: read addresses and the operation that rides with them
  // --------------------------------------------------------------------------
  always_comb begin
    ctl      = '{op: MAC_NONE, x_sel: X_A0, y_sel: Y_A1};
    // default addresses fetch the element and its transposed partner
    rd_addr0 = elem_addr(row_q, col_q);
    rd_addr1 = elem_addr(col_q, row_q);
    case (state_q)
      ST_DET: begin
        ctl.x_sel = mat_q ? X_B0 : X_A0;
        ctl.y_sel = mat_q ? Y_B1 : Y_A1;
        case (step_q)
          DET_T0: begin
            rd_addr0 = cof_addr(cof_q, 2'd0);
            rd_addr1 = cof_addr(cof_q, 2'd1);
            ctl.op   = MAC_LOAD;
          end
          DET_T1: begin
            rd_addr0 = cof_addr(cof_q, 2'd2);
            rd_addr1 = cof_addr(cof_q, 2'd3);
            ctl.op   = MAC_SUB;
          end
          DET_MUL: begin
            // first-row element times its minor, sign alternates
            rd_addr0  = ADDR_W'(cof_q);
            ctl.y_sel = Y_ACC;
            if (cof_q == NEG_COF) begin
              ctl.op = mat_q ? DB_SUB : DA_SUB;
            end else begin
              ctl.op = mat_q ? DB_ADD : DA_ADD;
            end
          end
          default: ;
        endcase
      end
      ST_PROD: begin
        if (step_q <= PROD_LAST_MAC) begin
          rd_addr0  = elem_addr(row_q, step_q[IDX_W-1:0]);
          rd_addr1  = elem_addr(step_q[IDX_W-1:0], col_q);
          ctl.x_sel = X_A0;
          ctl.y_sel = Y_B1;
          ctl.op    = (step_q == 3'd0) ? MAC_LOAD : MAC_ADD;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // multiplier operands, taken from the registered read data
  // --------------------------------------------------------------------------
  always_comb begin
    mul_x = (ctl1_q.x_sel == X_B0) ? rd_b0_q : rd_a0_q;
    case (ctl1_q.y_sel)
      Y_A1:    mul_y = ACC_W'(rd_a1_q);
      Y_B1:    mul_y = ACC_W'(rd_b1_q);
      Y_ACC:   mul_y = acc_q;
      default: mul_y = '0;
    endcase
  end

  assign mul_full = mul_x * mul_y;

  // pipeline control: issue -> read -> multiply -> accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '{op: MAC_NONE, x_sel: X_A0, y_sel: Y_A1};
      op2_q  <= MAC_NONE;
    end else begin
      ctl1_q <= ctl;
      op2_q  <= ctl1_q.op;
    end
  end

  // multiply and accumulate registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[DACC_W-1:0];
    if (set_done) begin
      det_a_q <= '0;
      det_b_q <= '0;
    end else begin
      case (op2_q)
        MAC_LOAD: acc_q   <= prod_q[ACC_W-1:0];
        MAC_ADD:  acc_q   <= acc_q + prod_q[ACC_W-1:0];
        MAC_SUB:  acc_q   <= acc_q - prod_q[ACC_W-1:0];
        DA_ADD:   det_a_q <= det_a_q + prod_q;
        DA_SUB:   det_a_q <= det_a_q - prod_q;
        DB_ADD:   det_b_q <= det_b_q + prod_q;
        DB_SUB:   det_b_q <= det_b_q - prod_q;
        default:  ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      mat_q       <= 1'b0;
      cof_q       <= '0;
      step_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_sum_q   <= '0;
      out_diff_q  <= '0;
      out_prod_q  <= '0;
      out_tr_a_q  <= '0;
      out_tr_b_q  <= '0;
      out_det_a_q <= '0;
      out_det_b_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // the emit step handles the output register on its own
      if (out_valid_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_cnt_q == LAST_ADDR) begin
              // ninth element pair in: start on the determinants
              load_cnt_q <= '0;
              state_q    <= ST_DET;
              mat_q      <= 1'b0;
              cof_q      <= '0;
              step_q     <= '0;
            end else begin
              load_cnt_q <= load_cnt_q + 1'b1;
            end
          end
        end
        ST_DET: begin
          if (step_q == DET_MUL) begin
            step_q <= '0;
            if (cof_q == LAST_COF) begin
              cof_q <= '0;
              if (mat_q) begin
                state_q <= ST_PROD;
                row_q   <= '0;
                col_q   <= '0;
              end else begin
                mat_q <= 1'b1;
              end
            end else begin
              cof_q <= cof_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_PROD: begin
          if (step_q == PROD_DONE) begin
            step_q  <= '0;
            state_q <= ST_EMIT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_EMIT: begin
          // accumulator holds the product element, read ports hold the
          // element pair and its transposed partners
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= row_q;
            out_col_q   <= col_q;
            out_sum_q   <= SUM_W'(rd_a0_q) + SUM_W'(rd_b0_q);
            out_diff_q  <= SUM_W'(rd_a0_q) - SUM_W'(rd_b0_q);
            out_prod_q  <= acc_q[PROD_W-1:0];
            out_tr_a_q  <= rd_a1_q;
            out_tr_b_q  <= rd_b1_q;
            out_det_a_q <= last_elem ? det_a_q[DET_W-1:0] : '0;
            out_det_b_q <= last_elem ? det_b_q[DET_W-1:0] : '0;
            out_last_q  <= last_elem;
            if (last_elem) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_PROD;
              if (col_q == LAST_IDX) begin
                col_q <= '0;
                row_q <= row_q + 1'b1;
              end else begin
                col_q <= col_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.row         = out_row_q;
  assign out_o.col         = out_col_q;
  assign out_o.sum         = out_sum_q;
  assign out_o.difference  = out_diff_q;
  assign out_o.product     = out_prod_q;
  assign out_o.transpose_a = out_tr_a_q;
  assign out_o.transpose_b = out_tr_b_q;
  assign out_o.det_a       = out_det_a_q;
  assign out_o.det_b       = out_det_b_q;
  assign out_o.last        = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // the ninth load starts the determinant pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_done |=> (state_q == ST_DET))
    else $error("ninth load did not start the determinant pass");

  // pipeline is drained whenever a result is written out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (ctl1_q.op == MAC_NONE) && (op2_q == MAC_NONE))
    else $error("result emitted with multiply-accumulate still in flight");

  // a stalled result stays put until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid && $stable(out_o.row)
      && $stable(out_o.col) && $stable(out_o.product) && $stable(out_o.last))
    else $error("result changed while stalled");

  // no loading while a set is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (load_cnt_q == '0))
    else $error("load count nonzero during computation");

endmodule
